/* rtl/thfu_pkg.sv */
// ----------------------------------------------------------------------------
// thfu_pkg
// Shared types and constants of the terrain height field update block.
// ----------------------------------------------------------------------------
package thfu_pkg;

  // coordinate width, covers frame sizes up to 8191
  localparam int CW = 13;

  localparam logic [7:0] INIT_HEIGHT = 8'd96;
  localparam logic [7:0] INIT_LUMA   = 8'd16;
  localparam logic [7:0] RIDGE_BASE  = 8'd48;
  localparam logic [7:0] UPHEAVAL_BASE = 8'd32;
  localparam logic [6:0] SMOOTH_MUL  = 7'd82;
  localparam logic [7:0] FEED_BASE   = 8'd150;
  localparam logic [7:0] FEED_OFFSET = 8'd8;
  localparam logic [7:0] FEED_MAX    = 8'd180;
  localparam logic [7:0] TARGET_BIAS = 8'd24;
  localparam logic [7:0] SETTLE_MID  = 8'd128;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for x < 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_DEPOSIT_LEVEL = 3'd2,
    REG_MEMORY_LEVEL  = 3'd3,
    REG_EROSION_LEVEL = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] ridge_mul;
    logic [7:0] heave_mul;
    logic [6:0] blur_mul;
    logic [7:0] feed;
    logic [3:0] settle;
  } gains_t;

  typedef struct packed {
    logic valid;
    logic in_frame;
    logic last;
  } item_ctl_t;

  typedef logic signed [11:0] val_t;
  typedef logic signed [19:0] prod_t;

endpackage

/* rtl/thfu_ram.sv */
// ----------------------------------------------------------------------------
// thfu_ram
// Byte memory, one write port, two registered read ports, read before write.
// ----------------------------------------------------------------------------
module thfu_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [7:0]    rdata0,
  output logic [7:0]    rdata1
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

/* rtl/thfu_gain.sv */
// ----------------------------------------------------------------------------
// thfu_gain
// Derives the per-frame gains from the level registers, two register steps.
// ----------------------------------------------------------------------------
module thfu_gain import thfu_pkg::*; (
  input  logic       clk,
  input  logic [6:0] deposit_level,
  input  logic [6:0] memory_level,
  input  logic [6:0] erosion_level,
  output gains_t     gains
);

  logic [13:0] smooth_prod;
  logic [14:0] feed_prod;
  logic [7:0]  ridge_g1, upheaval_g1;
  logic [3:0]  settle_g1;
  logic [27:0] smooth_q;
  logic [27:0] feed_q;
  logic [8:0]  feed_raw;

  always_ff @(posedge clk) begin
    smooth_prod <= 14'(erosion_level) * 14'(SMOOTH_MUL);
    feed_prod   <= 15'(deposit_level) * 15'(FEED_BASE - 8'(memory_level >> 1));
    ridge_g1    <= RIDGE_BASE + 8'(deposit_level);
    upheaval_g1 <= UPHEAVAL_BASE + 8'(deposit_level);
    settle_g1   <= erosion_level[6:3];
  end

  assign smooth_q = 28'(smooth_prod) * 28'(RECIP_100);
  assign feed_q   = 28'(feed_prod) * 28'(RECIP_100);
  assign feed_raw = 9'(FEED_OFFSET) + 9'(feed_q >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    gains.ridge_mul <= ridge_g1;
    gains.heave_mul <= upheaval_g1;
    gains.blur_mul  <= 7'd4 + 7'(smooth_q >> RECIP_SHIFT);
    gains.feed      <= (feed_raw > 9'(FEED_MAX)) ? FEED_MAX : feed_raw[7:0];
    gains.settle    <= settle_g1;
  end

endmodule

/* rtl/thfu_calc.sv */
// ----------------------------------------------------------------------------
// thfu_calc
// Height arithmetic stages, output register with skid entry, write-back port.
// ----------------------------------------------------------------------------
module thfu_calc import thfu_pkg::*; #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  gains_t        gains,
  input  item_ctl_t     ctl2,
  input  logic [AW-1:0] addr2,
  input  logic [7:0]    yc2,
  input  logic [7:0]    edge2,
  input  logic [7:0]    motion2,
  input  logic [7:0]    hc,
  input  logic [7:0]    hl,
  input  logic [7:0]    hr,
  input  logic [7:0]    hu,
  input  logic [7:0]    hd,
  output logic          adv,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          swap_done,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    new_height,
  output logic          frame_done
);

  item_ctl_t     ctl3, ctl4, ctl5;
  logic [AW-1:0] addr3, addr4, addr5;
  logic [7:0]    avg3, old3, yc3;
  logic [8:0]    ridge3, uph3;
  val_t          target4, smoothed4, nh5;
  logic [9:0]    nsum;
  logic [15:0]   ridge_p, uph_p;
  val_t          target_raw, sm_diff, fd_diff, st_diff, nh_raw;
  prod_t         sm_prod, fd_prod, st_prod;
  prod_t         sm_sh, fd_sh, st_sh;
  logic [7:0]    fin_height;
  logic          push;
  logic          skid_valid;
  logic [7:0]    skid_height;
  logic          skid_done;

  assign adv  = !skid_valid;
  assign push = adv && ctl5.valid;

  // stage 3: neighbour average, scaled edge and motion
  assign nsum    = 10'(hl) + 10'(hr) + 10'(hu) + 10'(hd);
  assign ridge_p = 16'(edge2) * 16'(gains.ridge_mul);
  assign uph_p   = 16'(motion2) * 16'(gains.heave_mul);

  // stage 4: target and smoothing
  assign target_raw = val_t'(yc3) + val_t'(ridge3) + val_t'(uph3) - val_t'(TARGET_BIAS);
  assign sm_diff    = val_t'(avg3) - val_t'(old3);
  assign sm_prod    = prod_t'(sm_diff) * prod_t'({1'b0, gains.blur_mul});
  assign sm_sh      = sm_prod >>> 8;

  // stage 5: feed toward target
  assign fd_diff = target4 - smoothed4;
  assign fd_prod = prod_t'(fd_diff) * prod_t'({1'b0, gains.feed});
  assign fd_sh   = fd_prod >>> 8;

  // final: settle toward mid level, clamp
  assign st_diff = val_t'(SETTLE_MID) - nh5;
  assign st_prod = prod_t'(st_diff) * prod_t'({1'b0, gains.settle});
  assign st_sh   = st_prod >>> 8;
  assign nh_raw  = nh5 + val_t'(st_sh);

  always_comb begin
    if (!ctl5.in_frame) begin
      fin_height = 8'd0;
    end else if (nh_raw < 0) begin
      fin_height = 8'd0;
    end else if (nh_raw > 12'sd255) begin
      fin_height = 8'd255;
    end else begin
      fin_height = nh_raw[7:0];
    end
  end

  assign wr_en     = push && ctl5.in_frame;
  assign wr_addr   = addr5;
  assign wr_data   = fin_height;
  assign swap_done = push && ctl5.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
    end else if (adv) begin
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr3  <= addr2;
      avg3   <= nsum[9:2];
      old3   <= hc;
      yc3    <= yc2;
      ridge3 <= ridge_p[15:7];
      uph3   <= uph_p[15:7];
      addr4  <= addr3;
      if (target_raw < 0) begin
        target4 <= '0;
      end else if (target_raw > 12'sd255) begin
        target4 <= 12'sd255;
      end else begin
        target4 <= target_raw;
      end
      smoothed4 <= val_t'(old3) + val_t'(sm_sh);
      addr5     <= addr4;
      nh5       <= smoothed4 + val_t'(fd_sh);
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        new_height <= skid_height;
        frame_done <= skid_done;
      end else if (push) begin
        new_height <= fin_height;
        frame_done <= ctl5.last;
      end
    end else if (push) begin
      skid_height <= fin_height;
      skid_done   <= ctl5.last;
    end
  end

endmodule

/* rtl/terrain_height_field_update_top.sv */
// ----------------------------------------------------------------------------
// terrain_height_field_update_top
// Terrain height field update: one luma pixel in, one height out per beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): pixel position plus center luma and its
// four clamped neighbours. Output channel (out_valid/out_ready): new height
// and frame_done, high on the frame's last pixel when the planes swap.
// Config: APB registers at 0x00 width, 0x04 height, 0x08 deposit,
// 0x0C memory, 0x10 erosion. Write only while the block is idle.
// Throughput: one beat per cycle while no stall holds the pipeline and no plane
// swap is pending. Each beat passes the stage registers and the output register.
// After the last pixel of a frame, in_ready drops until that pixel's height
// is written back, since the next frame reads that plane.
// The old plane is read at five places per pixel; each plane is kept in three
// copies of a two-read-port memory to serve all five reads in the same cycle.
// Reset: a clearing pass over all MAX_WIDTH*MAX_HEIGHT addresses fills the height
// planes with 96 and the previous-luma plane with 16; in_ready stays low.
// Stall: when out_ready is low, one more result lands in a skid entry, then
// the whole pipeline holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module terrain_height_field_update_top import thfu_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic [7:0]  luma_center,
  input  logic [7:0]  luma_left,
  input  logic [7:0]  luma_right,
  input  logic [7:0]  luma_up,
  input  logic [7:0]  luma_down,
  // height output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  new_height,
  output logic        frame_done
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // config registers
  logic [8:0] frame_width, frame_height;
  logic [6:0] deposit_level, memory_level, erosion_level;
  gains_t     gains;

  // control
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          plane_sel;
  logic          swap_pend;
  logic          adv;
  logic          in_fire;
  logic          wr_en, swap_done;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // frame geometry
  logic [CW-1:0] fw, fh, w_eff, h_eff, xin, yin, xl, xr, yup, ydn;
  logic          in_frame, is_last;
  logic [AW-1:0] a_c, a_l, a_r, a_u, a_d;

  // stage 1
  item_ctl_t     ctl1;
  logic [7:0]    yc1, yl1, yr1, yu1, yd1;
  logic [AW-1:0] a_c1, a_l1, a_r1, a_u1, a_d1;
  logic [7:0]    prev1;
  logic [7:0]    edge_lr, edge_ud;
  logic [8:0]    edge_sum;

  // stage 2
  item_ctl_t     ctl2;
  logic [7:0]    yc2, edge2, motion2;
  logic [AW-1:0] a_c2;
  logic [7:0]    rd [2][3][2];
  logic [7:0]    hc, hl, hr, hu, hd;

  // ---------------- APB ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 9'd256;
      frame_height  <= 9'd256;
      deposit_level <= 7'd62;
      memory_level  <= 7'd66;
      erosion_level <= 7'd22;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_FRAME_WIDTH:   frame_width   <= pwdata[8:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[8:0];
        REG_DEPOSIT_LEVEL: deposit_level <= pwdata[6:0];
        REG_MEMORY_LEVEL:  memory_level  <= pwdata[6:0];
        REG_EROSION_LEVEL: erosion_level <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_FRAME_WIDTH:   prdata = 32'(frame_width);
      REG_FRAME_HEIGHT:  prdata = 32'(frame_height);
      REG_DEPOSIT_LEVEL: prdata = 32'(deposit_level);
      REG_MEMORY_LEVEL:  prdata = 32'(memory_level);
      REG_EROSION_LEVEL: prdata = 32'(erosion_level);
      default:           prdata = '0;
    endcase
  end

  thfu_gain u_gain (
    .clk           (clk),
    .deposit_level (deposit_level),
    .memory_level  (memory_level),
    .erosion_level (erosion_level),
    .gains         (gains)
  );

  // ---------------- control ----------------
  assign in_ready = adv && !clearing && !swap_pend;
  assign in_fire  = in_valid && in_ready;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // plane swap waits for the last pixel's write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_pend <= 1'b0;
      plane_sel <= 1'b0;
    end else begin
      if (in_fire && is_last) begin
        swap_pend <= 1'b1;
      end else if (swap_done) begin
        swap_pend <= 1'b0;
      end
      if (swap_done) begin
        plane_sel <= !plane_sel;
      end
    end
  end

  // ---------------- geometry and addresses ----------------
  function automatic logic [AW-1:0] idx_of(input logic [CW-1:0] yy, input logic [CW-1:0] xx);
    logic [31:0] t;
    t = 32'(yy) * 32'(MAX_WIDTH) + 32'(xx);
    return t[AW-1:0];
  endfunction

  assign fw  = CW'(frame_width);
  assign fh  = CW'(frame_height);
  assign xin = CW'(pixel_x);
  assign yin = CW'(pixel_y);

  always_comb begin
    if (fw == '0) begin
      w_eff = CW'(1);
    end else if (fw > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = fw;
    end
    if (fh == '0) begin
      h_eff = CW'(1);
    end else if (fh > CW'(MAX_HEIGHT)) begin
      h_eff = CW'(MAX_HEIGHT);
    end else begin
      h_eff = fh;
    end
  end

  assign in_frame = (xin < w_eff) && (yin < h_eff);
  assign is_last  = in_frame && (xin == w_eff - 1'b1) && (yin == h_eff - 1'b1);
  assign xl  = (xin == '0) ? w_eff - 1'b1 : xin - 1'b1;
  assign xr  = (xin == w_eff - 1'b1) ? '0 : xin + 1'b1;
  assign yup = (yin == '0) ? h_eff - 1'b1 : yin - 1'b1;
  assign ydn = (yin == h_eff - 1'b1) ? '0 : yin + 1'b1;

  assign a_c = idx_of(yin, xin);
  assign a_l = idx_of(yin, xl);
  assign a_r = idx_of(yin, xr);
  assign a_u = idx_of(yup, xin);
  assign a_d = idx_of(ydn, xin);

  // ---------------- previous luma plane ----------------
  // read and overwritten in the accept cycle
  thfu_ram #(.DEPTH(DEPTH), .AW(AW)) u_prev (
    .clk    (clk),
    .we     (clearing || (in_fire && in_frame)),
    .waddr  (clearing ? clr_addr : a_c),
    .wdata  (clearing ? INIT_LUMA : luma_center),
    .re     (in_fire),
    .raddr0 (a_c),
    .raddr1 (a_c),
    .rdata0 (prev1),
    .rdata1 ()
  );

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (adv) begin
      ctl1.valid    <= in_fire;
      ctl1.in_frame <= in_frame;
      ctl1.last     <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      yc1  <= luma_center;
      yl1  <= luma_left;
      yr1  <= luma_right;
      yu1  <= luma_up;
      yd1  <= luma_down;
      a_c1 <= a_c;
      a_l1 <= a_l;
      a_r1 <= a_r;
      a_u1 <= a_u;
      a_d1 <= a_d;
    end
  end

  // ---------------- height planes ----------------
  // plane p, copy k; copy 0 serves center/left, 1 right/up, 2 down
  for (genvar p = 0; p < 2; p++) begin : g_plane
    for (genvar k = 0; k < 3; k++) begin : g_copy
      thfu_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .clk    (clk),
        .we     (clearing || (wr_en && (plane_sel != 1'(p)))),
        .waddr  (clearing ? clr_addr : wr_addr),
        .wdata  (clearing ? INIT_HEIGHT : wr_data),
        .re     (adv),
        .raddr0 ((k == 0) ? a_c1 : (k == 1) ? a_r1 : a_d1),
        .raddr1 ((k == 0) ? a_l1 : (k == 1) ? a_u1 : a_d1),
        .rdata0 (rd[p][k][0]),
        .rdata1 (rd[p][k][1])
      );
    end
  end

  // ---------------- stage 2 ----------------
  assign edge_lr  = (yr1 > yl1) ? yr1 - yl1 : yl1 - yr1;
  assign edge_ud  = (yd1 > yu1) ? yd1 - yu1 : yu1 - yd1;
  assign edge_sum = 9'(edge_lr) + 9'(edge_ud);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (adv) begin
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yc2     <= yc1;
      a_c2    <= a_c1;
      edge2   <= edge_sum[8] ? 8'd255 : edge_sum[7:0];
      motion2 <= (yc1 > prev1) ? yc1 - prev1 : prev1 - yc1;
    end
  end

  // old plane select, stable while items of a frame are in flight
  assign hc = rd[plane_sel][0][0];
  assign hl = rd[plane_sel][0][1];
  assign hr = rd[plane_sel][1][0];
  assign hu = rd[plane_sel][1][1];
  assign hd = rd[plane_sel][2][0];

  // ---------------- stages 3..5 and output ----------------
  thfu_calc #(.AW(AW)) u_calc (
    .clk        (clk),
    .rst        (rst),
    .gains      (gains),
    .ctl2       (ctl2),
    .addr2      (a_c2),
    .yc2        (yc2),
    .edge2      (edge2),
    .motion2    (motion2),
    .hc         (hc),
    .hl         (hl),
    .hr         (hr),
    .hu         (hu),
    .hd         (hd),
    .adv        (adv),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .swap_done  (swap_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .new_height (new_height),
    .frame_done (frame_done)
  );

endmodule

/* rtl/thfu_checker.sv */
// ----------------------------------------------------------------------------
// thfu_checker
// Port-level checks of the terrain height field update block.
// ----------------------------------------------------------------------------
module thfu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] new_height,
  input logic       frame_done
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_height) && $stable(frame_done))
    else $error("output beat changed while stalled");

  // clearing pass keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("input ready right after reset");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind terrain_height_field_update_top thfu_checker u_thfu_checker (.*);

/* bench/tb_terrain_height_field_update_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terrain_height_field_update_top
// Self-checking bench for the terrain height field update block.
// ----------------------------------------------------------------------------
// A directed table goes first. Its rows carry a typed-in height where the
// value is plain: pixels outside the frame give zero. Random frames follow.
// Each frame is a raster pass with random luma under a random register
// setting. A software copy of the height, luma and plane-select state
// predicts every beat. Both sides idle at random. There is also a long
// receiver hold-off and a sender pause until all results have drained.
// ----------------------------------------------------------------------------
module tb_terrain_height_field_update_top import thfu_pkg::*; ();

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int PLANE = MAXW * MAXH;
  localparam int DRAIN_CYCLES = 16;
  // watchdog limit on idle cycles, longer than the clearing pass after reset
  localparam int STALL_LIMIT = 4 * PLANE;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] pixel_x = '0, pixel_y = '0, luma_center = '0, luma_left = '0;
  logic [7:0] luma_right = '0, luma_up = '0, luma_down = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] new_height;
  logic frame_done;

  terrain_height_field_update_top #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) DUT (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // one pixel beat
  typedef struct {
    logic [7:0] x, y, c, l, r, u, d;
  } pixel_t;

  // expected output beat
  typedef struct {
    logic [7:0] height;
    logic       done;
  } height_t;

  // mirror of the block's state and registers
  logic [7:0] hgt_a [PLANE];
  logic [7:0] hgt_b [PLANE];
  logic [7:0] prev_luma [PLANE];
  bit         sel_b;
  int unsigned cfg_w, cfg_h, cfg_dep, cfg_mem, cfg_ero;

  height_t expected_heights[$];
  int errors = 0;
  int beats_in = 0, beats_out = 0, frames_done = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH beat %0d %s: got %0d want %0d", beats_out, what, got, want);
  endtask

  function automatic int shr8_floor(int v);
    return v >>> 8;  // arithmetic shift floors for signed int
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int absd(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  // advance the state mirror by one pixel and return its result
  function automatic height_t update_height(pixel_t p);
    height_t res;
    int w, h, x, y, idx, xl, xr, yup, ydn;
    int rg, ug, sg, feed, settle, oh, avg, grad, motion, tgt, sm, nh;
    w = clampi(cfg_w, 1, MAXW);
    h = clampi(cfg_h, 1, MAXH);
    x = p.x;
    y = p.y;
    res.height = '0;
    res.done = 1'b0;
    if (x >= w || y >= h) return res;
    rg = 48 + cfg_dep;
    ug = 32 + cfg_dep;
    sg = 4 + (cfg_ero * 82) / 100;
    feed = clampi(8 + (cfg_dep * (150 - (cfg_mem >> 1))) / 100, 0, 180);
    settle = cfg_ero >> 3;
    idx = y * MAXW + x;
    xl = x > 0 ? x - 1 : w - 1;
    xr = x < w - 1 ? x + 1 : 0;
    yup = y > 0 ? y - 1 : h - 1;
    ydn = y < h - 1 ? y + 1 : 0;
    if (sel_b) begin
      oh = hgt_b[idx];
      avg = (hgt_b[y*MAXW+xl] + hgt_b[y*MAXW+xr] + hgt_b[yup*MAXW+x]
             + hgt_b[ydn*MAXW+x]) >> 2;
    end else begin
      oh = hgt_a[idx];
      avg = (hgt_a[y*MAXW+xl] + hgt_a[y*MAXW+xr] + hgt_a[yup*MAXW+x]
             + hgt_a[ydn*MAXW+x]) >> 2;
    end
    grad = absd(p.r, p.l) + absd(p.d, p.u);
    if (grad > 255) grad = 255;
    motion = absd(p.c, prev_luma[idx]);
    tgt = clampi(int'(p.c) + ((grad * rg) >> 7) + ((motion * ug) >> 7) - 24, 0, 255);
    sm = oh + shr8_floor((avg - oh) * sg);
    nh = sm + shr8_floor((tgt - sm) * feed);
    nh += shr8_floor((128 - nh) * settle);
    nh = clampi(nh, 0, 255);
    if (sel_b) hgt_a[idx] = nh[7:0];
    else hgt_b[idx] = nh[7:0];
    prev_luma[idx] = p.c;
    res.height = nh[7:0];
    res.done = (x == w - 1) && (y == h - 1);
    if (res.done) sel_b = ~sel_b;
    return res;
  endfunction

  // APB write: setup then access, both at clock edges
  task automatic reg_write(reg_idx_t r, int unsigned val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(4 * int'(r)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_FRAME_WIDTH:   cfg_w = val & 9'h1FF;
      REG_FRAME_HEIGHT:  cfg_h = val & 9'h1FF;
      REG_DEPOSIT_LEVEL: cfg_dep = val & 7'h7F;
      REG_MEMORY_LEVEL:  cfg_mem = val & 7'h7F;
      REG_EROSION_LEVEL: cfg_ero = val & 7'h7F;
      default: ;
    endcase
  endtask

  // sender goes quiet; valid was left high after the last accepted beat
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // quiesce: stop sending and wait for all results, then a further drain wait
  task automatic wait_idle();
    stop_sending();
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned w, int unsigned h, int unsigned dep,
                          int unsigned mem, int unsigned ero);
    wait_idle();
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_DEPOSIT_LEVEL, dep);
    reg_write(REG_MEMORY_LEVEL, mem);
    reg_write(REG_EROSION_LEVEL, ero);
  endtask

  // present one beat; random pre-gap, hold until accepted, valid stays high
  task automatic send_pixel(pixel_t p, bit gap);
    int unsigned pause;
    pause = gap ? $urandom_range(0, 5) : 0;
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= p.x; pixel_y <= p.y; luma_center <= p.c;
    luma_left <= p.l; luma_right <= p.r; luma_up <= p.u; luma_down <= p.d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_heights.push_back(update_height(p));
    beats_in++;
  endtask

  // raster pass with random luma; neighbours clamped at edges as a source would
  task automatic send_frame(int w, int h, bit gap);
    logic [7:0] img [];
    pixel_t p;
    img = new[w * h];
    foreach (img[i]) img[i] = 8'($urandom_range(0, 255));
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        p.x = 8'(x); p.y = 8'(y); p.c = img[y*w+x];
        p.l = img[y*w + (x > 0 ? x-1 : x)];
        p.r = img[y*w + (x < w-1 ? x+1 : x)];
        p.u = img[(y > 0 ? y-1 : y)*w + x];
        p.d = img[(y < h-1 ? y+1 : y)*w + x];
        // occasional noise: arbitrary neighbours, or an extra beat at a random position
        if ($urandom_range(0, 19) == 0) begin
          p.l = 8'($urandom); p.r = 8'($urandom); p.u = 8'($urandom); p.d = 8'($urandom);
        end
        send_pixel(p, gap && $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 39) == 0) begin
          p.x = 8'($urandom); p.y = 8'($urandom);
          send_pixel(p, 1'b0);
        end
      end
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off && !hold_taken) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_taken = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker, sampled at the edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      height_t want;
      beats_out++;
      if (expected_heights.size() == 0) begin
        report("unexpected beat", new_height, -1);
      end else begin
        want = expected_heights.pop_front();
        if (new_height !== want.height) report("new_height", new_height, want.height);
        if (frame_done !== want.done) report("frame_done", frame_done, want.done);
        if (frame_done === 1'b1) frames_done++;
      end
    end
  end

  // watchdog: cycles with no accepted beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Watchdog expired with %0d results pending", expected_heights.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // directed rows: expected height typed in where obvious, else predicted
  typedef struct {
    pixel_t pix;
    bit     typed;
    logic [7:0] height;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{'{8'd4, 8'd0, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9}, 1'b1, 8'd0},
    '{'{8'd0, 8'd4, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1, 8'd0},
    '{'{8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 8'd0},
    '{'{8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{'{8'd1, 8'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b0, 8'd0},
    '{'{8'd2, 8'd0, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0, 8'd0},
    '{'{8'd3, 8'd0, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0, 8'd0},
    '{'{8'd0, 8'd1, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0, 8'd0},
    '{'{8'd3, 8'd3, 8'h80, 8'h10, 8'hF0, 8'h10, 8'hF0}, 1'b0, 8'd0},
    '{'{8'd0, 8'd0, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10}, 1'b0, 8'd0}
  };

  initial begin
    int w, h;
    cfg_w = 256; cfg_h = 256; cfg_dep = 62; cfg_mem = 66; cfg_ero = 22;
    sel_b = 1'b0;
    for (int i = 0; i < PLANE; i++) begin
      hgt_a[i] = INIT_HEIGHT; hgt_b[i] = INIT_HEIGHT; prev_luma[i] = INIT_LUMA;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: 4x4 frame, reset gains; covers off-frame positions and a plane swap
    set_regs(4, 4, 62, 66, 22);
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].pix, 1'b0);
      if (dir_rows[i].typed && expected_heights[$].height !== dir_rows[i].height)
        report("typed row", expected_heights[$].height, dir_rows[i].height);
    end
    // level extremes, out-of-range frame sizes (0 and 511 clamp)
    set_regs(0, 0, 0, 0, 0);
    send_frame(1, 1, 1'b0);
    set_regs(1, 511, 127, 127, 127);
    send_frame(1, 3, 1'b0);
    set_regs(2, 2, 100, 100, 100);
    send_frame(2, 2, 1'b0);
    send_frame(2, 2, 1'b0);

    // full-size frame setting, one pixel at the origin whose neighbours wrap to the far edges
    set_regs(256, 256, 62, 66, 22);
    send_frame(1, 1, 1'b1);

    // long receiver hold-off while the sender keeps going
    set_regs(8, 8, 50, 30, 60);
    hold_off = 1'b1;
    send_frame(8, 8, 1'b0);
    // sender pause until everything drained
    stop_sending();
    while (expected_heights.size() != 0) @(posedge clk);

    // random frames, small sizes mostly
    while (beats_in < 1600) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 10);
      h = $urandom_range(1, 10);
      set_regs(w, h, $urandom_range(0, 127), $urandom_range(0, 127),
               $urandom_range(0, 127));
      repeat ($urandom_range(1, 3)) send_frame(w, h, $urandom_range(0, 3) != 0);
    end

    // high corner of a max-size frame
    set_regs(256, 256, $urandom_range(0, 100), $urandom_range(0, 100), 100);
    begin
      pixel_t p;
      p = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
      send_pixel(p, 1'b0);
    end

    wait_idle();
    $display("Covered %0d input beats, %0d output beats, %0d completed frames",
             beats_in, beats_out, frames_done);
    $display("Register sweeps included level extremes and clamped frame sizes");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/thfu_pkg.sv
rtl/thfu_ram.sv
rtl/thfu_gain.sv
rtl/thfu_calc.sv
rtl/terrain_height_field_update_top.sv
rtl/thfu_checker.sv
bench/tb_terrain_height_field_update_top.sv
